@@ rtl/wbps_pkg.sv @@
// wbps_pkg: shared types and constants of the wildcard byte pattern scanner.
// No dependencies; used by every module of the block.
package wbps_pkg;

	typedef enum logic [1:0] {
		FUNC_LOAD    = 2'd0,
		FUNC_SCAN    = 2'd1,
		FUNC_RESTART = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		CAP_RAW       = 2'd0,
		CAP_RELATIVE  = 2'd1,
		CAP_PRECEDING = 2'd2
	} cap_mode_t;

	localparam logic [2:0] REG_PATTERN_LENGTH = 3'd0;
	localparam logic [2:0] REG_CAP0_OFFSET    = 3'd1;
	localparam logic [2:0] REG_CAP0_SIZE      = 3'd2;
	localparam logic [2:0] REG_CAP0_MODE      = 3'd3;
	localparam logic [2:0] REG_CAP1_OFFSET    = 3'd4;
	localparam logic [2:0] REG_CAP1_SIZE      = 3'd5;
	localparam logic [2:0] REG_CAP1_MODE      = 3'd6;

	localparam int CFG_W = 6;
	localparam logic [31:0] REL_WIDTH = 32'd4;
	localparam logic [31:0] PRECEDING_OFFSET = 32'd1;
	localparam logic [3:0] CAP_MAX_BYTES = 4'd8;

	typedef struct packed {
		logic [4:0] offset;
		logic [3:0] size;
		cap_mode_t  mode;
	} cap_cfg_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} win_ctl_t;

	typedef struct packed {
		logic       we;
		logic [4:0] index;
		logic [7:0] value;
		logic       care;
	} pat_load_t;

endpackage

@@ rtl/wbps_window.sv @@
// wbps_window: byte window shift line with fill count, aligned to the pattern.
// Depends on wbps_pkg (win_ctl_t).
module wbps_window #(
	parameter int PATTERN_MAX = 32,
	parameter int LW = $clog2(PATTERN_MAX + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wbps_pkg::win_ctl_t         ctl,
	input  logic [7:0]                 data_byte,
	input  logic [LW-1:0]              len,
	output logic [LW-1:0]              fill,
	output logic [8*PATTERN_MAX-1:0]   aligned
);

	logic [7:0] window_q [PATTERN_MAX];
	logic [LW-1:0] fill_q;
	logic [8*PATTERN_MAX-1:0] rev;
	logic [LW+2:0] shamt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PATTERN_MAX; i++) window_q[i] <= '0;
			fill_q <= '0;
		end else if (ctl.clear) begin
			for (int i = 0; i < PATTERN_MAX; i++) window_q[i] <= '0;
			fill_q <= '0;
		end else if (ctl.shift) begin
			window_q[0] <= data_byte;
			for (int i = 1; i < PATTERN_MAX; i++) window_q[i] <= window_q[i-1];
			if (fill_q != LW'(PATTERN_MAX)) fill_q <= fill_q + LW'(1);
		end
	end

	// oldest byte first, then drop the bytes older than the pattern
	always_comb begin
		for (int k = 0; k < PATTERN_MAX; k++) rev[8*k +: 8] = window_q[PATTERN_MAX-1-k];
		shamt = {LW'(PATTERN_MAX) - len, 3'b000};
		aligned = rev >> shamt;
	end

	assign fill = fill_q;

endmodule

@@ rtl/wbps_pattern.sv @@
// wbps_pattern: compiled pattern store and parallel compare against the window.
// Depends on wbps_pkg (pat_load_t).
module wbps_pattern #(
	parameter int PATTERN_MAX = 32,
	parameter int LW = $clog2(PATTERN_MAX + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wbps_pkg::pat_load_t        load,
	input  logic [8*PATTERN_MAX-1:0]   aligned,
	input  logic [LW-1:0]              len,
	input  logic [LW-1:0]              fill,
	output logic                       hit
);

	logic [7:0] pat_q [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] care_q;
	logic [PATTERN_MAX-1:0] ok;

	always_ff @(posedge clk) begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if (load.we && int'(load.index) == i) pat_q[i] <= load.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			care_q <= '0;
		end else begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				if (load.we && int'(load.index) == i) care_q[i] <= load.care;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			ok[i] = !care_q[i] || (i >= int'(len)) || (aligned[8*i +: 8] == pat_q[i]);
		end
		hit = (fill >= len) && (&ok);
	end

endmodule

@@ rtl/wbps_capture.sv @@
// wbps_capture: one capture slot: raw value, relative target or preceding address.
// Depends on wbps_pkg (cap_cfg_t, cap_mode_t, capture constants).
module wbps_capture #(
	parameter int PATTERN_MAX = 32
) (
	input  logic [8*PATTERN_MAX-1:0]   aligned,
	input  logic [31:0]                match,
	input  wbps_pkg::cap_cfg_t         cfg,
	output logic [63:0]                value
);

	logic [8*PATTERN_MAX+63:0] ext;
	logic [8*PATTERN_MAX+63:0] sh;
	logic [63:0] raw;
	logic [63:0] masked;
	logic [3:0] size_eff;

	always_comb begin
		size_eff = (cfg.size > wbps_pkg::CAP_MAX_BYTES) ? wbps_pkg::CAP_MAX_BYTES : cfg.size;
		ext = {64'b0, aligned};
		sh = ext >> {cfg.offset, 3'b000};
		raw = sh[63:0];
		for (int k = 0; k < 8; k++) begin
			masked[8*k +: 8] = (k < int'(size_eff)) ? raw[8*k +: 8] : 8'h00;
		end
		value = '0;
		if (cfg.size != 4'd0) begin
			case (cfg.mode)
				wbps_pkg::CAP_RAW: begin
					value = masked;
				end
				wbps_pkg::CAP_RELATIVE: begin
					value = {32'b0, raw[31:0] + match + 32'(cfg.offset) + wbps_pkg::REL_WIDTH};
				end
				wbps_pkg::CAP_PRECEDING: begin
					value = {32'b0, match + 32'(cfg.offset) - wbps_pkg::PRECEDING_OFFSET};
				end
				default: begin
					value = '0;
				end
			endcase
		end
	end

endmodule

@@ rtl/wildcard_byte_pattern_scanner_top.sv @@
// wildcard_byte_pattern_scanner_top: scanner top level, control and result register.
// Depends on wbps_pkg, wbps_window, wbps_pattern, wbps_capture.
//
// Usage: the input channel carries one word per item: a pattern entry load
// (func 0), a scanned byte (func 1) or a scan restart (func 2). Bytes of a
// region arrive at consecutive addresses, last_byte marks the end. The output
// channel carries one word when the pattern first matches wholly inside the
// region (found 1) or when the region ends without one (found 0, all zero).
// After that word scan bytes are dropped until a restart.
// Throughput: one input word per cycle while in_stall is low. A scan byte is
// held in the compare stage, and its result is visible on out_valid from the
// result register: compare stage, then result register.
// Loads and restarts act at the edge that accepts them and give no word.
// When the receiver stalls, the result register holds; a further result in
// the compare stage raises in_stall until the register frees.
// Reset clears the window, fill count, done flag, care bits and registers
// (pattern length 1, capture slots unused). Configuration writes belong to
// idle periods.
module wildcard_byte_pattern_scanner_top #(
	parameter int PATTERN_MAX = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [5:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [4:0]  entry_index,
	input  logic [7:0]  entry_value,
	input  logic        entry_care,
	input  logic [31:0] byte_address,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [31:0] match_address,
	output logic [63:0] capture_zero,
	output logic [63:0] capture_one
);

	localparam int LW = $clog2(PATTERN_MAX + 1);

	logic [5:0] pattern_length_q;
	wbps_pkg::cap_cfg_t cap0_q, cap1_q;

	logic valid_s1;
	logic [31:0] byte_address_s1;
	logic last_byte_s1;
	logic done_q;

	logic out_valid_q, found_q;
	logic [31:0] match_address_q;
	logic [63:0] capture_zero_q, capture_one_q;

	logic [LW-1:0] len, fill;
	logic [8*PATTERN_MAX-1:0] aligned;
	logic hit;
	logic [31:0] match;
	logic [63:0] cap0_val, cap1_val;
	wbps_pkg::win_ctl_t win_ctl;
	wbps_pkg::pat_load_t pat_load;

	logic accept, fin_s1, out_free, adv_s1, done_eff, live_scan;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= 6'd1;
			cap0_q <= '{offset: 5'd0, size: 4'd0, mode: wbps_pkg::CAP_RAW};
			cap1_q <= '{offset: 5'd0, size: 4'd0, mode: wbps_pkg::CAP_RAW};
		end else if (cfg_write) begin
			case (cfg_index)
				wbps_pkg::REG_PATTERN_LENGTH: pattern_length_q <= cfg_data;
				wbps_pkg::REG_CAP0_OFFSET:    cap0_q.offset <= cfg_data[4:0];
				wbps_pkg::REG_CAP0_SIZE:      cap0_q.size <= cfg_data[3:0];
				wbps_pkg::REG_CAP0_MODE:      cap0_q.mode <= wbps_pkg::cap_mode_t'(cfg_data[1:0]);
				wbps_pkg::REG_CAP1_OFFSET:    cap1_q.offset <= cfg_data[4:0];
				wbps_pkg::REG_CAP1_SIZE:      cap1_q.size <= cfg_data[3:0];
				wbps_pkg::REG_CAP1_MODE:      cap1_q.mode <= wbps_pkg::cap_mode_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		if (pattern_length_q == 6'd0) begin
			len = LW'(1);
		end else if (int'(pattern_length_q) > PATTERN_MAX) begin
			len = LW'(PATTERN_MAX);
		end else begin
			len = LW'(pattern_length_q);
		end
		match = byte_address_s1 - 32'(len - LW'(1));
	end

	// handshake and stage control
	always_comb begin
		fin_s1 = valid_s1 && (hit || last_byte_s1);
		out_free = !out_valid_q || !out_stall;
		adv_s1 = !fin_s1 || out_free;
		in_stall = valid_s1 && !adv_s1;
		accept = in_valid && !in_stall;
		done_eff = done_q || fin_s1;
		live_scan = accept && (func == wbps_pkg::FUNC_SCAN) && !done_eff;
		win_ctl.shift = live_scan;
		win_ctl.clear = accept && (func == wbps_pkg::FUNC_RESTART);
		pat_load.we = accept && (func == wbps_pkg::FUNC_LOAD);
		pat_load.index = entry_index;
		pat_load.value = entry_value;
		pat_load.care = entry_care;
	end

	wbps_window #(.PATTERN_MAX(PATTERN_MAX), .LW(LW)) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (win_ctl),
		.data_byte (data_byte),
		.len       (len),
		.fill      (fill),
		.aligned   (aligned)
	);

	wbps_pattern #(.PATTERN_MAX(PATTERN_MAX), .LW(LW)) u_pattern (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (pat_load),
		.aligned (aligned),
		.len     (len),
		.fill    (fill),
		.hit     (hit)
	);

	wbps_capture #(.PATTERN_MAX(PATTERN_MAX)) u_capture0 (
		.aligned (aligned),
		.match   (match),
		.cfg     (cap0_q),
		.value   (cap0_val)
	);

	wbps_capture #(.PATTERN_MAX(PATTERN_MAX)) u_capture1 (
		.aligned (aligned),
		.match   (match),
		.cfg     (cap1_q),
		.value   (cap1_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= live_scan;
			if (win_ctl.clear) begin
				done_q <= 1'b0;
			end else if (fin_s1 && adv_s1) begin
				done_q <= 1'b1;
			end
			if (out_free) out_valid_q <= fin_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (live_scan) begin
			byte_address_s1 <= byte_address;
			last_byte_s1 <= last_byte;
		end
		if (fin_s1 && out_free) begin
			found_q <= hit;
			match_address_q <= hit ? match : 32'd0;
			capture_zero_q <= hit ? cap0_val : 64'd0;
			capture_one_q <= hit ? cap1_val : 64'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign found = found_q;
	assign match_address = match_address_q;
	assign capture_zero = capture_zero_q;
	assign capture_one = capture_one_q;

	a_no_scan_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && done_q))
		else $error("scan word in compare stage while scan is done");

	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall && fin_s1))
		else $error("input stalled without a blocked result");

	a_blocked_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_s1 && !out_free) |=> valid_s1)
		else $error("blocked result lost from compare stage");

	a_no_match_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !found_q) |-> (match_address_q == 32'd0 &&
			capture_zero_q == 64'd0 && capture_one_q == 64'd0))
		else $error("end-of-region word carries nonzero payload");

endmodule
